/* rtl/core/msc_pkg.sv */
package msc_pkg;

  // Register map of the configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_RELOAD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RELOAD = 8'd1;

  localparam logic [CFG_DATA_W-1:0] SECOND_RELOAD_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] REPEAT_RELOAD_RST = 16'd200;

  // Item opcodes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SCAN = 1'b1
  } opcode_t;

  // Display geometry
  localparam logic [2:0] NUM_POS  = 3'd5;
  localparam logic [2:0] LAST_POS = 3'd4;
  localparam logic [2:0] DASH_POS = 3'd2;
  localparam logic [7:0] SEG_DASH = 8'h40;

  localparam logic [5:0] TIME_RST   = 6'd58;
  localparam logic [6:0] TIME_LIMIT = 7'd60;

  typedef struct packed {
    logic [7:0] segment_code;
    logic [4:0] digit_select;
  } result_t;

  // Hex font, bit0 = segment a
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h58;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // Tens of a 6-bit value: floor(v * 13 / 128) is exact for v < 64
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = {4'd0, v} * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  // Ones of a 6-bit value
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [6:0] t10;
    logic [6:0] r;
    t10 = {3'd0, tens_of(v)} * 7'd10;
    r = {1'b0, v} - t10;
    return r[3:0];
  endfunction

endpackage

/* rtl/core/msc_if.sv */
// Input item channel
interface msc_in_if;
  import msc_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  logic    button_one_down;
  logic    button_two_down;
  modport source (output valid, opcode, button_one_down, button_two_down, input ready);
  modport sink   (input valid, opcode, button_one_down, button_two_down, output ready);
endinterface

// Result channel
interface msc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_code;
  logic [4:0] digit_select;
  modport source (output valid, segment_code, digit_select, input ready);
  modport sink   (input valid, segment_code, digit_select, output ready);
endinterface

// Configuration write channel
interface msc_cfg_if;
  import msc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/minute_second_clock_with_set_buttons_core.sv */
// Channel   Dir  Payload                                  Transfer when
// in_chan   in   opcode, button_one_down, button_two_down valid & ready
// out_chan  out  segment_code[7:0], digit_select[4:0]     valid & ready
// cfg_chan  in   index[7:0], data[15:0]                   valid & ready (ready always 1)
//
// One item per cycle while in_chan.ready is high; a scan result is registered
// into the output register, or the skid entry while stalled. Tick items give no result.
// Reset (rst_n low, synchronous) sets 58:58, clears countdowns, flags,
// scan position and both output stages, and restores the reload values.
// An output register plus one skid entry: in_chan.ready drops only while
// the skid entry is occupied, so ticks and one more scan pass through a
// stalled output.
module minute_second_clock_with_set_buttons_core
  import msc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  msc_in_if.sink    in_chan,
  msc_out_if.source out_chan,
  msc_cfg_if.sink   cfg_chan
);

  // Configuration
  logic [15:0] second_reload_r, second_reload_nxt;
  logic [15:0] repeat_reload_r, repeat_reload_nxt;

  // Clock state
  logic [5:0]  minutes_r, minutes_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  logic [15:0] second_cd_r, second_cd_nxt;
  logic [15:0] repeat_cd_r, repeat_cd_nxt;
  logic        second_flag_r, second_flag_nxt;
  logic        repeat_flag_r, repeat_flag_nxt;
  logic        b1_held_r, b1_held_nxt;
  logic        b2_held_r, b2_held_nxt;
  logic [2:0]  scan_pos_r, scan_pos_nxt;
  logic [3:0]  shown_digits_r [4];

  // Output stages
  logic        out_v_r, out_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  result_t     out_data_r, out_data_nxt;
  result_t     skid_data_r, skid_data_nxt;

  logic        in_fire, tick_fire, scan_fire, out_fire, cfg_fire;
  logic [2:0]  pos;
  logic [1:0]  digit_idx;
  logic [3:0]  fresh_digits [4];
  logic [3:0]  digit;
  result_t     new_res;
  logic [6:0]  sec_sum;
  logic [6:0]  min_sum;
  logic        sec_tick_inc, b1_rpt_inc, b2_rpt_inc, b1_rel_inc, b2_rel_inc, sec_carry;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign tick_fire = in_fire && (in_chan.opcode == OP_TICK);
  assign scan_fire = in_fire && (in_chan.opcode == OP_SCAN);
  assign out_fire  = out_chan.valid && out_chan.ready;
  assign cfg_fire  = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready         = !skid_v_r;
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_v_r;
  assign out_chan.segment_code = out_data_r.segment_code;
  assign out_chan.digit_select = out_data_r.digit_select;

  // Configuration writes; indexes beyond the map are dropped
  always_comb begin
    second_reload_nxt = second_reload_r;
    repeat_reload_nxt = repeat_reload_r;
    if (cfg_fire && (cfg_chan.index == REG_SECOND_RELOAD)) begin
      second_reload_nxt = cfg_chan.data;
    end
    if (cfg_fire && (cfg_chan.index == REG_REPEAT_RELOAD)) begin
      repeat_reload_nxt = cfg_chan.data;
    end
  end

  // Display word for this scan position
  always_comb begin
    pos = (scan_pos_r > LAST_POS) ? 3'd0 : scan_pos_r;
    fresh_digits[0] = tens_of(minutes_r);
    fresh_digits[1] = ones_of(minutes_r);
    fresh_digits[2] = tens_of(seconds_r);
    fresh_digits[3] = ones_of(seconds_r);
    digit_idx = (pos < DASH_POS) ? pos[1:0] : 2'(pos - 3'd1);
    // position 0 shows the snapshot it is taking
    digit = (pos == 3'd0) ? fresh_digits[0] : shown_digits_r[digit_idx];
    new_res.segment_code = (pos == DASH_POS) ? SEG_DASH : seg_font(digit);
    new_res.digit_select = 5'(5'd1 << pos);
    scan_pos_nxt = scan_pos_r;
    if (scan_fire) begin
      scan_pos_nxt = (pos >= LAST_POS) ? 3'd0 : 3'(pos + 3'd1);
    end
  end

  // Time update on a scan pass
  always_comb begin
    sec_tick_inc = second_flag_r && !b1_held_r && !b2_held_r;
    b1_rpt_inc   = repeat_flag_r && b1_held_r;
    b2_rpt_inc   = repeat_flag_r && b2_held_r;
    b1_rel_inc   = b1_held_r && !in_chan.button_one_down;
    b2_rel_inc   = b2_held_r && !in_chan.button_two_down;
    sec_sum = {1'b0, seconds_r} + {6'd0, sec_tick_inc} + {6'd0, b1_rpt_inc}
              + {6'd0, b1_rel_inc};
    sec_carry = (sec_sum >= TIME_LIMIT);
    min_sum = {1'b0, minutes_r} + {6'd0, b2_rpt_inc} + {6'd0, b2_rel_inc}
              + {6'd0, sec_carry};

    minutes_nxt     = minutes_r;
    seconds_nxt     = seconds_r;
    b1_held_nxt     = b1_held_r;
    b2_held_nxt     = b2_held_r;
    second_flag_nxt = second_flag_r;
    repeat_flag_nxt = repeat_flag_r;
    second_cd_nxt   = second_cd_r;
    repeat_cd_nxt   = repeat_cd_r;

    if (scan_fire) begin
      seconds_nxt     = sec_carry ? 6'd0 : sec_sum[5:0];
      minutes_nxt     = (min_sum >= TIME_LIMIT) ? 6'd0 : min_sum[5:0];
      b1_held_nxt     = in_chan.button_one_down;
      b2_held_nxt     = in_chan.button_two_down;
      second_flag_nxt = 1'b0;
      repeat_flag_nxt = 1'b0;
    end

    // Millisecond countdowns
    if (tick_fire) begin
      if (repeat_cd_r == 16'd0) begin
        repeat_cd_nxt   = repeat_reload_r;
        repeat_flag_nxt = 1'b1;
      end else begin
        repeat_cd_nxt = repeat_cd_r - 16'd1;
      end
      if (second_cd_r == 16'd0) begin
        second_cd_nxt   = second_reload_r;
        second_flag_nxt = 1'b1;
      end else begin
        second_cd_nxt = second_cd_r - 16'd1;
      end
    end
  end

  // Output register and skid entry
  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_v_nxt     = 1'b1;
        out_data_nxt  = skid_data_r;
        skid_v_nxt    = scan_fire;
        skid_data_nxt = new_res;
      end else begin
        out_v_nxt    = scan_fire;
        out_data_nxt = new_res;
      end
    end else if (scan_fire) begin
      skid_v_nxt    = 1'b1;
      skid_data_nxt = new_res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_reload_r <= SECOND_RELOAD_RST;
      repeat_reload_r <= REPEAT_RELOAD_RST;
      minutes_r       <= TIME_RST;
      seconds_r       <= TIME_RST;
      second_cd_r     <= '0;
      repeat_cd_r     <= '0;
      second_flag_r   <= 1'b0;
      repeat_flag_r   <= 1'b0;
      b1_held_r       <= 1'b0;
      b2_held_r       <= 1'b0;
      scan_pos_r      <= '0;
      out_v_r         <= 1'b0;
      skid_v_r        <= 1'b0;
    end else begin
      second_reload_r <= second_reload_nxt;
      repeat_reload_r <= repeat_reload_nxt;
      minutes_r       <= minutes_nxt;
      seconds_r       <= seconds_nxt;
      second_cd_r     <= second_cd_nxt;
      repeat_cd_r     <= repeat_cd_nxt;
      second_flag_r   <= second_flag_nxt;
      repeat_flag_r   <= repeat_flag_nxt;
      b1_held_r       <= b1_held_nxt;
      b2_held_r       <= b2_held_nxt;
      scan_pos_r      <= scan_pos_nxt;
      out_v_r         <= out_v_nxt;
      skid_v_r        <= skid_v_nxt;
    end
  end

  // Payload: result stages and the digit snapshot
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (scan_fire && (pos == 3'd0)) begin
      shown_digits_r <= fresh_digits;
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry occupied while output register empty");

  a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire |=> out_v_r)
    else $error("scan transfer produced no result");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (minutes_r < 6'd60) && (seconds_r < 6'd60))
    else $error("time out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_pos_r < NUM_POS)
    else $error("scan position out of range");

endmodule
